// ----- src/psvm_pkg.sv -----
package psvm_pkg;

  localparam int PHASE_W  = 32;
  localparam int ENERGY_W = 24;
  localparam int EIN_W    = 16;
  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 16;
  localparam int FUNC_W   = 3;
  localparam int VOICE_W  = 4;
  localparam int DS_W     = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;
  // energy (unsigned Q0.24) times sine (signed Q1.15)
  localparam int PROD_W   = 40;

  localparam logic [FUNC_W-1:0] FUNC_TICK       = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_NOTE_ON    = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_NOTE_OFF   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_SET_ENERGY = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_QUERY      = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY     = 1'b1;

  localparam logic [ENERGY_W-1:0] THR_RESET   = 24'd838861;
  localparam logic [DS_W-1:0]     DECAY_RESET = 5'd12;

  // pi/2 in Q16
  localparam logic [16:0] PI_HALF_Q16 = 17'd102944;

  // Exact floor division of a 29-bit value: q = (n * M) >> S, M = ceil(2^S / d)
  localparam int DIV3_S   = 31;
  localparam int DIV15_S  = 33;
  localparam int DIV315_S = 38;
  localparam logic [29:0] DIV3_M   = 30'(((64'd1 << DIV3_S) + 64'd2) / 64'd3);
  localparam logic [29:0] DIV15_M  = 30'(((64'd1 << DIV15_S) + 64'd14) / 64'd15);
  localparam logic [29:0] DIV315_M = 30'(((64'd1 << DIV315_S) + 64'd314) / 64'd315);

  typedef struct packed {
    logic [PHASE_W-1:0]  phase;
    logic [ENERGY_W-1:0] energy;
  } voice_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [VOICE_W-1:0]  voice_id;
    logic                ok;
    logic                active;
    logic [LEVEL_W-1:0]  level;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK_RD,
    ST_TICK_DRAIN,
    ST_TICK_DIV,
    ST_TICK_SAT,
    ST_OP_RD,
    ST_OP_USE,
    ST_DONE
  } state_e;

endpackage

// ----- src/psvm_voice_mac.sv -----
module psvm_voice_mac #(
  parameter int SINE_ADDR_BITS = 10
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  vld_i,
  input  logic        [psvm_pkg::PHASE_W-1:0]   phase_i,
  input  logic        [psvm_pkg::ENERGY_W-1:0]  energy_i,
  output logic                                  busy_o,
  output logic                                  vld_o,
  output logic signed [psvm_pkg::PROD_W-1:0]    prod_o
);

  localparam int QB     = SINE_ADDR_BITS - 2;
  localparam int STAGES = 10;

  logic [STAGES-1:0] vld_q;
  logic              sgn_q [STAGES-2];
  logic [psvm_pkg::ENERGY_W-1:0] e_q [STAGES-1];

  // quarter-wave folding
  logic [SINE_ADDR_BITS-1:0] idx;
  logic [1:0]                quad;
  logic [QB-1:0]             rem;
  logic [QB:0]               tq;
  logic [16:0]               u_d, u_q;

  logic [33:0] x_prod;
  logic [28:0] x1_q;
  logic [57:0] x2_prod;
  logic [29:0] x2_2_q;
  logic [28:0] xa2_q;
  logic [58:0] x3_prod;
  logic [29:0] x3_3_q, x2_3_q;
  logic [28:0] xa3_q;
  logic [59:0] x5_prod;
  logic [58:0] m3_prod;
  logic [31:0] x5_4_q;
  logic [58:0] m3_4_q;
  logic [29:0] x2_4_q;
  logic [28:0] xa4_q;
  logic [61:0] x7_prod;
  logic [58:0] m5_prod;
  logic [32:0] x7_5_q;
  logic [58:0] m5_5_q;
  logic [27:0] q3_5_q;
  logic [28:0] xa5_q;
  logic [58:0] m7_prod;
  logic [58:0] m7_6_q;
  logic [25:0] q5_6_q;
  logic [27:0] q3_6_q;
  logic [28:0] xa6_q;
  logic [29:0] tp_7_q, tn_7_q;
  logic [29:0] s_diff;
  logic [30:0] s_rnd;
  logic [17:0] r_val;
  logic [14:0] q15;
  logic signed [psvm_pkg::SAMPLE_W-1:0] sine_8_q;
  logic signed [psvm_pkg::ENERGY_W:0]   e_ext;
  logic signed [psvm_pkg::PROD_W:0]     p_full;
  logic signed [psvm_pkg::PROD_W-1:0]   prod_9_q;

  assign idx  = phase_i[psvm_pkg::PHASE_W-1 -: SINE_ADDR_BITS];
  assign quad = idx[SINE_ADDR_BITS-1 -: 2];
  assign rem  = idx[QB-1:0];
  assign tq   = quad[0] ? ((QB+1)'(1) << QB) - {1'b0, rem} : {1'b0, rem};
  assign u_d  = {tq, {(16 - QB){1'b0}}};

  assign x_prod  = u_q * psvm_pkg::PI_HALF_Q16;
  assign x2_prod = x1_q * x1_q;
  assign x3_prod = x2_2_q * xa2_q;
  assign x5_prod = x3_3_q * x2_3_q;
  assign m3_prod = x3_3_q[29:1] * psvm_pkg::DIV3_M;
  assign x7_prod = x5_4_q * x2_4_q;
  assign m5_prod = x5_4_q[31:3] * psvm_pkg::DIV15_M;
  assign m7_prod = x7_5_q[32:4] * psvm_pkg::DIV315_M;

  // x - x^3/6 + x^5/120 - x^7/5040, floored at zero, rounded to Q15
  assign s_diff = (tp_7_q > tn_7_q) ? tp_7_q - tn_7_q : '0;
  assign s_rnd  = {1'b0, s_diff} + 31'd4096;
  assign r_val  = s_rnd[30:13];
  assign q15    = (r_val > 18'd32767) ? 15'h7FFF : r_val[14:0];

  assign e_ext  = $signed({1'b0, e_q[STAGES-2]});
  assign p_full = e_ext * sine_8_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[STAGES-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    sgn_q[0] <= quad[1];
    e_q[0]   <= energy_i;
    for (int i = 1; i < STAGES - 2; i++) begin
      sgn_q[i] <= sgn_q[i-1];
    end
    for (int i = 1; i < STAGES - 1; i++) begin
      e_q[i] <= e_q[i-1];
    end
    u_q      <= u_d;
    x1_q     <= x_prod[32:4];
    x2_2_q   <= x2_prod[57:28];
    xa2_q    <= x1_q;
    x3_3_q   <= x3_prod[57:28];
    x2_3_q   <= x2_2_q;
    xa3_q    <= xa2_q;
    x5_4_q   <= x5_prod[59:28];
    m3_4_q   <= m3_prod;
    x2_4_q   <= x2_3_q;
    xa4_q    <= xa3_q;
    x7_5_q   <= x7_prod[60:28];
    m5_5_q   <= m5_prod;
    q3_5_q   <= m3_4_q[58:psvm_pkg::DIV3_S];
    xa5_q    <= xa4_q;
    m7_6_q   <= m7_prod;
    q5_6_q   <= m5_5_q[58:psvm_pkg::DIV15_S];
    q3_6_q   <= q3_5_q;
    xa6_q    <= xa5_q;
    tp_7_q   <= 30'(xa6_q) + 30'(q5_6_q);
    tn_7_q   <= 30'(q3_6_q) + 30'(m7_6_q[58:psvm_pkg::DIV315_S]);
    sine_8_q <= sgn_q[STAGES-3] ? -$signed({1'b0, q15}) : $signed({1'b0, q15});
    prod_9_q <= p_full[psvm_pkg::PROD_W-1:0];
  end

  assign busy_o = |vld_q;
  assign vld_o  = vld_q[STAGES-1];
  assign prod_o = prod_9_q;

endmodule

// ----- src/polyphonic_sine_voice_mixer.sv -----
// Bank of VOICE_COUNT sine voices kept in two synchronous memories (phase with
// energy, and phase increment), each with one read and one write port; active
// and hold flags are flops. A tick walks the voices one memory read per cycle
// and, until the next item is accepted, passes through the VOICE_COUNT reads,
// the 10-stage sine and multiply pipeline, accumulation of the last product,
// leaving the drain, the divide by the voice count, saturation, the output
// register and the return to idle. Note on, note off and unused codes go
// straight to the done state; set energy and query pass through a read and a
// use state, as they read the voice entry first. The output register lets the
// next item be taken while a result waits. Configuration is written through
// cfg_we_i with cfg_idx_i 0 for the release threshold and 1 for the decay shift.
module polyphonic_sine_voice_mixer #(
  parameter int VOICE_COUNT    = 16,
  parameter int FRAME_LEN      = 1024,
  parameter int SINE_ADDR_BITS = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [psvm_pkg::FUNC_W-1:0]         func_i,
  input  logic [psvm_pkg::VOICE_W-1:0]        voice_i,
  input  logic [psvm_pkg::PHASE_W-1:0]        phase_inc_i,
  input  logic [psvm_pkg::EIN_W-1:0]          energy_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [psvm_pkg::SAMPLE_W-1:0] sample_o,
  output logic [psvm_pkg::VOICE_W-1:0]        voice_id_o,
  output logic                                ok_o,
  output logic                                active_o,
  output logic [psvm_pkg::LEVEL_W-1:0]        level_o,
  input  logic                                cfg_we_i,
  input  logic [psvm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [psvm_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int VID_W = $clog2(VOICE_COUNT);
  localparam int VX_W  = VID_W + psvm_pkg::VOICE_W;
  localparam int FP_W  = (FRAME_LEN > 1) ? $clog2(FRAME_LEN) : 1;
  localparam int ACC_W = psvm_pkg::PROD_W + VID_W;
  localparam int MIX_W = ACC_W - psvm_pkg::ENERGY_W;
  // floor(a / VOICE_COUNT) done as reciprocal multiply on a biased, positive value
  localparam int DN_W  = MIX_W + 1;
  localparam int DS    = DN_W + VID_W;
  localparam int DM_W  = DN_W + 1;
  localparam int DP_W  = DN_W + DM_W;
  localparam int DQ_W  = DP_W - DS;
  localparam longint unsigned DIV_BIAS_L = longint'(VOICE_COUNT) << psvm_pkg::SAMPLE_W;
  localparam longint unsigned DIV_M_L    =
      ((64'd1 << DS) + longint'(VOICE_COUNT) - 64'd1) / longint'(VOICE_COUNT);
  localparam logic [DN_W-1:0] DIV_BIAS   = DN_W'(DIV_BIAS_L);
  localparam logic [DM_W-1:0] DIV_M      = DM_W'(DIV_M_L);
  localparam logic [DQ_W:0]   DIV_OFFSET = (DQ_W+1)'(64'd1 << psvm_pkg::SAMPLE_W);

  psvm_pkg::state_e state_q, state_d;

  logic [VID_W-1:0] cnt_q, cnt_d;
  logic [FP_W-1:0]  frame_q, frame_d;
  logic             frame_end_q, frame_end_d;
  logic [VOICE_COUNT-1:0] active_q, active_d, hold_q, hold_d;
  logic [psvm_pkg::ENERGY_W-1:0] thr_q;
  logic [psvm_pkg::DS_W-1:0]     decay_q;

  logic [psvm_pkg::FUNC_W-1:0] item_func_q;
  logic [VID_W-1:0]            item_vidx_q;
  logic                        item_valid_q;
  logic [psvm_pkg::EIN_W-1:0]  item_en_q;

  psvm_pkg::voice_t              pe_mem_q [VOICE_COUNT];
  logic [psvm_pkg::PHASE_W-1:0]  inc_mem_q [VOICE_COUNT];
  psvm_pkg::voice_t              pe_rd_q;
  logic [psvm_pkg::PHASE_W-1:0]  inc_rd_q;
  logic [VID_W-1:0]              rd_addr;
  logic                          pe_we, inc_we;
  logic [VID_W-1:0]              pe_wa;
  psvm_pkg::voice_t              pe_wd;

  logic             s1_vld_q;
  logic [VID_W-1:0] s1_idx_q;
  logic [psvm_pkg::ENERGY_W-1:0] s1_e, s1_e_new;
  logic [psvm_pkg::PHASE_W-1:0]  s1_ph_new;
  logic             s1_free;

  logic                               mac_busy, mac_vld;
  logic signed [psvm_pkg::PROD_W-1:0] mac_prod;

  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic [DN_W-1:0]         div_n;
  logic [DP_W-1:0]         dprod_q;
  logic [DQ_W-1:0]         div_q;
  logic [DQ_W:0]           smp_full;
  logic [psvm_pkg::SAMPLE_W-1:0] smp_sat;

  psvm_pkg::res_t res_q, res_d, out_q;
  logic           out_valid_q;

  logic             in_fire, tick_issue, out_load;
  logic [VX_W-1:0]  in_vx, free_vx;
  logic [VID_W-1:0] in_vidx, free_idx;
  logic             in_voice_ok, in_live, free_found, op_live;

  assign in_fire     = in_valid_i && !in_stall_o;
  assign in_vx       = {{VID_W{1'b0}}, voice_i};
  assign in_vidx     = in_vx[VID_W-1:0];
  assign in_voice_ok = in_vx < VX_W'(VOICE_COUNT);
  assign in_live     = in_voice_ok && active_q[in_vidx];
  assign op_live     = item_valid_q && active_q[item_vidx_q];

  // lowest free voice
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = VOICE_COUNT - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_found = 1'b1;
        free_idx   = VID_W'(i);
      end
    end
  end
  assign free_vx = {{psvm_pkg::VOICE_W{1'b0}}, free_idx};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      psvm_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (func_i)
            psvm_pkg::FUNC_TICK:       state_d = psvm_pkg::ST_TICK_RD;
            psvm_pkg::FUNC_SET_ENERGY: state_d = psvm_pkg::ST_OP_RD;
            psvm_pkg::FUNC_QUERY:      state_d = psvm_pkg::ST_OP_RD;
            default:                   state_d = psvm_pkg::ST_DONE;
          endcase
        end
      end
      psvm_pkg::ST_TICK_RD: begin
        if (cnt_q == VID_W'(VOICE_COUNT - 1)) state_d = psvm_pkg::ST_TICK_DRAIN;
      end
      psvm_pkg::ST_TICK_DRAIN: begin
        if (!s1_vld_q && !mac_busy) state_d = psvm_pkg::ST_TICK_DIV;
      end
      psvm_pkg::ST_TICK_DIV: state_d = psvm_pkg::ST_TICK_SAT;
      psvm_pkg::ST_TICK_SAT: state_d = psvm_pkg::ST_DONE;
      psvm_pkg::ST_OP_RD:    state_d = psvm_pkg::ST_OP_USE;
      psvm_pkg::ST_OP_USE:   state_d = psvm_pkg::ST_DONE;
      psvm_pkg::ST_DONE: begin
        if (out_load) state_d = psvm_pkg::ST_IDLE;
      end
      default: state_d = psvm_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o = 1'b1;
    tick_issue = 1'b0;
    rd_addr    = item_vidx_q;
    out_load   = 1'b0;
    case (state_q)
      psvm_pkg::ST_IDLE: in_stall_o = 1'b0;
      psvm_pkg::ST_TICK_RD: begin
        tick_issue = 1'b1;
        rd_addr    = cnt_q;
      end
      psvm_pkg::ST_DONE: out_load = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  // voice update, one voice behind the memory read
  assign s1_e      = pe_rd_q.energy;
  assign s1_e_new  = hold_q[s1_idx_q] ? s1_e : s1_e - (s1_e >> decay_q);
  assign s1_ph_new = pe_rd_q.phase + inc_rd_q;
  assign s1_free   = s1_vld_q && frame_end_q && !hold_q[s1_idx_q] && (s1_e_new <= thr_q);

  psvm_voice_mac #(
    .SINE_ADDR_BITS(SINE_ADDR_BITS)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (s1_vld_q),
    .phase_i (s1_ph_new),
    .energy_i(s1_e_new),
    .busy_o  (mac_busy),
    .vld_o   (mac_vld),
    .prod_o  (mac_prod)
  );

  // memory write port and flag updates
  always_comb begin
    active_d = active_q;
    hold_d   = hold_q;
    pe_we    = 1'b0;
    inc_we   = 1'b0;
    pe_wa    = s1_idx_q;
    pe_wd    = '{phase: s1_ph_new, energy: s1_e_new};
    if (in_fire && func_i == psvm_pkg::FUNC_NOTE_ON && free_found) begin
      active_d[free_idx] = 1'b1;
      hold_d[free_idx]   = 1'b1;
      pe_we              = 1'b1;
      inc_we             = 1'b1;
      pe_wa              = free_idx;
      pe_wd              = '0;
    end
    if (in_fire && func_i == psvm_pkg::FUNC_NOTE_OFF && in_live) begin
      hold_d[in_vidx] = 1'b0;
    end
    if (s1_vld_q) begin
      pe_we = 1'b1;
    end
    if (s1_free) begin
      active_d[s1_idx_q] = 1'b0;
    end
    if (state_q == psvm_pkg::ST_OP_USE && item_func_q == psvm_pkg::FUNC_SET_ENERGY &&
        op_live) begin
      pe_we = 1'b1;
      pe_wa = item_vidx_q;
      pe_wd = '{phase: pe_rd_q.phase,
                energy: {item_en_q, {(psvm_pkg::ENERGY_W - psvm_pkg::EIN_W){1'b0}}}};
    end
  end

  // tick bookkeeping and mix division
  assign div_n    = {acc_q[ACC_W-1], acc_q[ACC_W-1:psvm_pkg::ENERGY_W]} + DIV_BIAS;
  assign div_q    = dprod_q[DP_W-1:DS];
  assign smp_full = {1'b0, div_q} - DIV_OFFSET;

  always_comb begin
    if (!smp_full[DQ_W] && |smp_full[DQ_W-1:psvm_pkg::SAMPLE_W-1]) begin
      smp_sat = {1'b0, {(psvm_pkg::SAMPLE_W - 1){1'b1}}};
    end else if (smp_full[DQ_W] && !(&smp_full[DQ_W-1:psvm_pkg::SAMPLE_W-1])) begin
      smp_sat = {1'b1, {(psvm_pkg::SAMPLE_W - 1){1'b0}}};
    end else begin
      smp_sat = smp_full[psvm_pkg::SAMPLE_W-1:0];
    end
  end

  always_comb begin
    cnt_d       = cnt_q;
    frame_d     = frame_q;
    frame_end_d = frame_end_q;
    acc_d       = acc_q;
    if (in_fire && func_i == psvm_pkg::FUNC_TICK) begin
      frame_end_d = (frame_q == FP_W'(FRAME_LEN - 1));
      frame_d     = frame_end_d ? '0 : frame_q + FP_W'(1);
      cnt_d       = '0;
      acc_d       = '0;
    end
    if (tick_issue) begin
      cnt_d = cnt_q + VID_W'(1);
    end
    if (mac_vld) begin
      acc_d = acc_q + {{VID_W{mac_prod[psvm_pkg::PROD_W-1]}}, mac_prod};
    end
  end

  // result assembly
  always_comb begin
    res_d = res_q;
    if (in_fire) begin
      res_d = '0;
      case (func_i)
        psvm_pkg::FUNC_NOTE_ON: begin
          res_d.ok = free_found;
          if (free_found) res_d.voice_id = free_vx[psvm_pkg::VOICE_W-1:0];
        end
        psvm_pkg::FUNC_NOTE_OFF: res_d.ok = in_live;
        default: ;
      endcase
    end
    if (state_q == psvm_pkg::ST_TICK_SAT) begin
      res_d.sample = smp_sat;
      res_d.ok     = 1'b1;
    end
    if (state_q == psvm_pkg::ST_OP_USE) begin
      if (item_func_q == psvm_pkg::FUNC_SET_ENERGY) begin
        res_d.ok = op_live;
      end else begin
        res_d.ok     = item_valid_q;
        res_d.active = op_live;
        res_d.level  = op_live ? pe_rd_q.energy[psvm_pkg::ENERGY_W-1 -: psvm_pkg::LEVEL_W]
                               : '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pe_we) pe_mem_q[pe_wa] <= pe_wd;
    if (inc_we) inc_mem_q[free_idx] <= phase_inc_i;
    pe_rd_q  <= pe_mem_q[rd_addr];
    inc_rd_q <= inc_mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= psvm_pkg::ST_IDLE;
      cnt_q       <= '0;
      frame_q     <= '0;
      frame_end_q <= 1'b0;
      active_q    <= '0;
      hold_q      <= '0;
      thr_q       <= psvm_pkg::THR_RESET;
      decay_q     <= psvm_pkg::DECAY_RESET;
      s1_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      frame_q     <= frame_d;
      frame_end_q <= frame_end_d;
      active_q    <= active_d;
      hold_q      <= hold_d;
      s1_vld_q    <= tick_issue && active_q[cnt_q];
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          psvm_pkg::CFG_THRESHOLD: thr_q   <= cfg_data_i[psvm_pkg::ENERGY_W-1:0];
          psvm_pkg::CFG_DECAY:     decay_q <= cfg_data_i[psvm_pkg::DS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q <= cnt_q;
    acc_q    <= acc_d;
    dprod_q  <= div_n * DIV_M;
    res_q    <= res_d;
    if (out_load) out_q <= res_q;
    if (in_fire) begin
      item_func_q  <= func_i;
      item_vidx_q  <= in_vidx;
      item_valid_q <= in_voice_ok;
      item_en_q    <= energy_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = out_q.sample;
  assign voice_id_o  = out_q.voice_id;
  assign ok_o        = out_q.ok;
  assign active_o    = out_q.active;
  assign level_o     = out_q.level;

  // a held voice is always an allocated one
  a_hold_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hold_q & ~active_q) == '0)
    else $error("hold set on a free voice");

  // voices get allocated only by an accepted note on
  a_alloc_note_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($countones(active_q) > $countones($past(active_q))) |->
      $past(in_fire && func_i == psvm_pkg::FUNC_NOTE_ON))
    else $error("voice allocated without note on");

  // voice products come back only while the tick is still collecting them
  a_mac_in_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_vld |-> (state_q == psvm_pkg::ST_TICK_RD || state_q == psvm_pkg::ST_TICK_DRAIN))
    else $error("voice product outside tick");

  // a new result reaches the output only from the done state
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == psvm_pkg::ST_DONE))
    else $error("result presented without completion");

endmodule

// ----- tb/mixer_checker.sv -----
`timescale 1ns / 1ps
module mixer_checker #(
  parameter int VOICE_COUNT    = 16,
  parameter int FRAME_LEN      = 1024,
  parameter int SINE_ADDR_BITS = 10
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 in_stall_i,
  input  logic [psvm_pkg::FUNC_W-1:0]          func_i,
  input  logic [psvm_pkg::VOICE_W-1:0]         voice_i,
  input  logic [psvm_pkg::PHASE_W-1:0]         phase_inc_i,
  input  logic [psvm_pkg::EIN_W-1:0]           energy_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_stall_i,
  input  logic signed [psvm_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [psvm_pkg::VOICE_W-1:0]         voice_id_i,
  input  logic                                 ok_i,
  input  logic                                 active_i,
  input  logic [psvm_pkg::LEVEL_W-1:0]         level_i,
  input  logic                                 cfg_we_i,
  input  logic [psvm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [psvm_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output int                                   fail_count_o,
  output int                                   pending_o,
  output int                                   ticks_o,
  output int                                   freed_o,
  output int                                   refused_o
);
  import psvm_pkg::*;

  localparam longint unsigned HALF_PI_Q16   = 64'd102944;
  localparam longint          MIX_DIV       = longint'(VOICE_COUNT) << 24;
  localparam logic [ENERGY_W-1:0] FREE_LEVEL_INIT = 24'd838861;
  localparam logic [DS_W-1:0]     DECAY_SH_INIT   = 5'd12;

  logic                voice_on   [VOICE_COUNT];
  logic                voice_held [VOICE_COUNT];
  logic [PHASE_W-1:0]  voice_ph   [VOICE_COUNT];
  logic [PHASE_W-1:0]  voice_step [VOICE_COUNT];
  logic [ENERGY_W-1:0] voice_en   [VOICE_COUNT];
  int unsigned         frame_pos;
  logic [ENERGY_W-1:0] free_level;
  logic [DS_W-1:0]     decay_sh;
  res_t                results_due[$];
  int                  results_seen;

  // quarter-wave polynomial sine, Q15
  function automatic logic signed [SAMPLE_W-1:0] sine_q15(input logic [PHASE_W-1:0] ph);
    int unsigned qbits, idx, quad, r, t;
    longint unsigned u, x, x2, x3, x5, x7, pos, neg, s, q;
    logic signed [SAMPLE_W-1:0] mag;
    qbits = SINE_ADDR_BITS - 2;
    idx   = ph >> (PHASE_W - SINE_ADDR_BITS);
    quad  = (idx >> qbits) & 3;
    r     = idx & ((1 << qbits) - 1);
    t     = ((quad & 1) != 0) ? (1 << qbits) - r : r;
    u     = longint'(t) << (16 - qbits);
    x     = (u * HALF_PI_Q16) >> 4;
    x2    = (x * x) >> 28;
    x3    = (x2 * x) >> 28;
    x5    = (x3 * x2) >> 28;
    x7    = (x5 * x2) >> 28;
    pos   = x + x5 / 120;
    neg   = x3 / 6 + x7 / 5040;
    s     = (pos > neg) ? pos - neg : 0;
    q     = (s + 4096) >> 13;
    if (q > 32767) q = 32767;
    mag = q[SAMPLE_W-1:0];
    return ((quad & 2) != 0) ? -mag : mag;
  endfunction

  task automatic advance_voices(output logic [SAMPLE_W-1:0] smp);
    longint acc, e_l, s_l, q;
    int i;
    acc = 0;
    for (i = 0; i < VOICE_COUNT; i++) begin
      if (voice_on[i]) begin
        if (!voice_held[i]) voice_en[i] = voice_en[i] - (voice_en[i] >> decay_sh);
        voice_ph[i] = voice_ph[i] + voice_step[i];
        e_l = voice_en[i];
        s_l = sine_q15(voice_ph[i]);
        acc += e_l * s_l;
      end
    end
    // floor division, also for a negative mix
    if (acc >= 0) q = acc / MIX_DIV;
    else q = -((-acc + MIX_DIV - 1) / MIX_DIV);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    smp = q[SAMPLE_W-1:0];
    ticks_o++;
    frame_pos++;
    if (frame_pos >= FRAME_LEN) begin
      frame_pos = 0;
      for (i = 0; i < VOICE_COUNT; i++) begin
        if (voice_on[i] && !voice_held[i] && voice_en[i] <= free_level) begin
          voice_on[i] = 1'b0;
          freed_o++;
        end
      end
    end
  endtask

  task automatic apply_item(input logic [FUNC_W-1:0] f, input logic [VOICE_W-1:0] v,
                            input logic [PHASE_W-1:0] inc, input logic [EIN_W-1:0] en,
                            output res_t r);
    logic                in_range, live;
    logic [SAMPLE_W-1:0] smp;
    int                  slot, i;
    r        = '0;
    in_range = int'(v) < VOICE_COUNT;
    live     = in_range && voice_on[v];
    case (f)
      FUNC_TICK: begin
        advance_voices(smp);
        r.sample = smp;
        r.ok     = 1'b1;
      end
      FUNC_NOTE_ON: begin
        slot = -1;
        for (i = 0; i < VOICE_COUNT && slot < 0; i++) begin
          if (!voice_on[i]) slot = i;
        end
        if (slot < 0) begin
          refused_o++;
        end else begin
          voice_on[slot]   = 1'b1;
          voice_held[slot] = 1'b1;
          voice_ph[slot]   = '0;
          voice_en[slot]   = '0;
          voice_step[slot] = inc;
          r.voice_id       = slot[VOICE_W-1:0];
          r.ok             = 1'b1;
        end
      end
      FUNC_NOTE_OFF: begin
        if (live) begin
          voice_held[v] = 1'b0;
          r.ok          = 1'b1;
        end
      end
      FUNC_SET_ENERGY: begin
        if (live) begin
          voice_en[v] = {en, 8'h00};
          r.ok        = 1'b1;
        end
      end
      FUNC_QUERY: begin
        r.ok = in_range;
        if (live) begin
          r.active = 1'b1;
          r.level  = voice_en[v][ENERGY_W-1:8];
        end
      end
      default: ;
    endcase
  endtask

  task automatic flag_error(input string what, input logic [31:0] got_v,
                            input logic [31:0] want_v);
    $display("%0t ns: result %0d %s: got %0h, expected %0h",
             $time, results_seen, what, got_v, want_v);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t got, want, pred;
    int   i;
    if (!rst_ni) begin
      for (i = 0; i < VOICE_COUNT; i++) begin
        voice_on[i]   = 1'b0;
        voice_held[i] = 1'b0;
        voice_ph[i]   = '0;
        voice_step[i] = '0;
        voice_en[i]   = '0;
      end
      frame_pos    = 0;
      free_level   = FREE_LEVEL_INIT;
      decay_sh     = DECAY_SH_INIT;
      results_due.delete();
      results_seen = 0;
      fail_count_o = 0;
      pending_o    = 0;
      ticks_o      = 0;
      freed_o      = 0;
      refused_o    = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_THRESHOLD) free_level = cfg_data_i[ENERGY_W-1:0];
        else if (cfg_idx_i == CFG_DECAY) decay_sh = cfg_data_i[DS_W-1:0];
      end
      // results first: one accepted this edge stems from an older input
      if (out_valid_i && !out_stall_i) begin
        got.sample   = sample_i;
        got.voice_id = voice_id_i;
        got.ok       = ok_i;
        got.active   = active_i;
        got.level    = level_i;
        if (results_due.size() == 0) begin
          flag_error("arrived with nothing outstanding", 32'(got.sample), '0);
        end else begin
          want = results_due.pop_front();
          if (got.sample !== want.sample) flag_error("sample", got.sample, want.sample);
          if (got.voice_id !== want.voice_id)
            flag_error("voice_id", got.voice_id, want.voice_id);
          if (got.ok !== want.ok) flag_error("ok", got.ok, want.ok);
          if (got.active !== want.active) flag_error("active", got.active, want.active);
          if (got.level !== want.level) flag_error("level", got.level, want.level);
        end
        results_seen++;
      end
      if (in_valid_i && !in_stall_i) begin
        apply_item(func_i, voice_i, phase_inc_i, energy_i, pred);
        results_due.push_back(pred);
      end
      pending_o = results_due.size();
    end
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import psvm_pkg::*;

  localparam int VOICES       = 16;
  localparam int FRAME_TICKS  = 1024;
  localparam int SINE_BITS    = 10;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 137;
  localparam int DRAIN_CYCLES = 64;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic [FUNC_W-1:0]           func_i;
  logic [VOICE_W-1:0]          voice_i;
  logic [PHASE_W-1:0]          phase_inc_i;
  logic [EIN_W-1:0]            energy_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic signed [SAMPLE_W-1:0]  sample_o;
  logic [VOICE_W-1:0]          voice_id_o;
  logic                        ok_o;
  logic                        active_o;
  logic [LEVEL_W-1:0]          level_o;
  logic                        cfg_we_i;
  logic [CFG_IDX_W-1:0]        cfg_idx_i;
  logic [CFG_DATA_W-1:0]       cfg_data_i;

  int fail_count, pending, ticks, freed, refused;
  int items_sent;
  bit idle_on;
  logic [ENERGY_W-1:0] thr_plan   [PHASES];
  logic [DS_W-1:0]     shift_plan [PHASES];

  polyphonic_sine_voice_mixer #(
    .VOICE_COUNT   (VOICES),
    .FRAME_LEN     (FRAME_TICKS),
    .SINE_ADDR_BITS(SINE_BITS)
  ) i_dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .func_i, .voice_i, .phase_inc_i, .energy_i,
    .out_valid_o, .out_stall_i, .sample_o, .voice_id_o, .ok_o, .active_o, .level_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  mixer_checker #(
    .VOICE_COUNT   (VOICES),
    .FRAME_LEN     (FRAME_TICKS),
    .SINE_ADDR_BITS(SINE_BITS)
  ) i_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .func_i, .voice_i, .phase_inc_i, .energy_i,
    .out_valid_i(out_valid_o), .out_stall_i, .sample_i(sample_o),
    .voice_id_i(voice_id_o), .ok_i(ok_o), .active_i(active_o), .level_i(level_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending), .ticks_o(ticks),
    .freed_o(freed), .refused_o(refused)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // result side back-pressure
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Timeout: mixer stopped making progress");
    $display("CHECKS FAILED");
    $finish;
  end

  // one transfer on the input channel, with an optional idle burst ahead of it
  task automatic push_item(input logic [FUNC_W-1:0] f, input logic [VOICE_W-1:0] v,
                           input logic [PHASE_W-1:0] inc, input logic [EIN_W-1:0] en);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    func_i      <= f;
    voice_i     <= v;
    phase_inc_i <= inc;
    energy_i    <= en;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic random_item();
    int                 roll;
    logic [FUNC_W-1:0]  f;
    logic [PHASE_W-1:0] inc;
    logic [EIN_W-1:0]   en;
    // mostly ticks, so decay and mixing get the most exercise
    roll = $urandom_range(0, 99);
    if (roll < 80) f = FUNC_TICK;
    else if (roll < 85) f = FUNC_NOTE_ON;
    else if (roll < 90) f = FUNC_NOTE_OFF;
    else if (roll < 95) f = FUNC_SET_ENERGY;
    else if (roll < 99) f = FUNC_QUERY;
    else f = FUNC_QUERY + FUNC_W'($urandom_range(1, 3));
    case ($urandom_range(0, 5))
      0:       inc = '0;
      1:       inc = '1;
      2:       inc = $urandom_range(0, 32'h00FF_FFFF);
      default: inc = $urandom();
    endcase
    case ($urandom_range(0, 5))
      0:       en = '0;
      1:       en = '1;
      2:       en = EIN_W'($urandom_range(0, 255));
      default: en = EIN_W'($urandom());
    endcase
    push_item(f, VOICE_W'($urandom_range(0, VOICES - 1)), inc, en);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_for_drain();
    do @(negedge clk_i); while (pending != 0);
  endtask

  initial begin
    int                    ph, n, k;
    logic [PHASE_W-1:0]    inc;
    logic [CFG_DATA_W-1:0] word;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    func_i      <= '0;
    voice_i     <= '0;
    phase_inc_i <= '0;
    energy_i    <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_data_i  <= '0;
    items_sent  = 0;
    idle_on     = 1'b1;

    thr_plan[1] = '1;                       shift_plan[1] = 5'd1;
    thr_plan[2] = ENERGY_W'($urandom());    shift_plan[2] = 5'd20;
    thr_plan[3] = '0;                       shift_plan[3] = 5'd0;
    thr_plan[4] = ENERGY_W'($urandom());    shift_plan[4] = '1;
    thr_plan[5] = ENERGY_W'($urandom());    shift_plan[5] = DS_W'($urandom_range(1, 4));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // fill the bank first so no voice entry is read before it was written
    for (k = 0; k < VOICES; k++) begin
      case (k)
        0:       inc = '0;
        1:       inc = '1;
        2:       inc = 32'h8000_0000;
        3:       inc = 32'h0000_0001;
        default: inc = $urandom();
      endcase
      push_item(FUNC_NOTE_ON, VOICE_W'(VOICES - 1 - k), inc, '1);
    end
    push_item(FUNC_NOTE_ON, '0, 32'h1234_5678, '0);   // bank full
    push_item(FUNC_TICK, '0, '0, '0);                 // held voices, zero energy
    push_item(FUNC_SET_ENERGY, 4'd1, '0, '1);
    push_item(FUNC_SET_ENERGY, 4'd15, '1, '1);
    push_item(FUNC_SET_ENERGY, 4'd3, '0, 16'h0001);
    push_item(FUNC_TICK, '1, '1, '1);
    push_item(FUNC_QUERY, 4'd1, '0, '0);
    push_item(FUNC_NOTE_OFF, 4'd15, '0, '0);
    push_item(FUNC_TICK, '0, '0, '0);                 // first decay step
    push_item(FUNC_QUERY, 4'd15, '0, '0);
    push_item(FUNC_QUERY + FUNC_W'(3), '1, '1, '1);   // unused code

    for (ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) begin
        wait_for_drain();
        @(posedge clk_i);
        cfg_write(CFG_THRESHOLD, CFG_DATA_W'(thr_plan[ph]));
        // upper bits are don't-care for the decay shift
        word = CFG_DATA_W'($urandom());
        word[DS_W-1:0] = shift_plan[ph];
        cfg_write(CFG_DECAY, word);
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 50 == 0) idle_on = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
        random_item();
      end
      in_valid_i <= 1'b0;
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d items over %0d register settings: %0d ticks, %0d voices freed",
             items_sent, PHASES, ticks, freed);
    $display("at frame ends, %0d note-ons refused on a full bank.", refused);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/psvm_pkg.sv
src/psvm_voice_mac.sv
src/polyphonic_sine_voice_mixer.sv
tb/mixer_checker.sv
tb/tb.sv
